>>> hw/rtl/dst_pkg.sv
// Shared types, request codes and fixed-point helpers for the spring table.
// No dependencies; dst_recip, the table module and the bench import this package.
`default_nettype none
package dst_pkg;

  localparam int WORD_W = 32;
  localparam int THR_W  = 31;
  localparam int DT_W   = 16;
  localparam int DT_BITS = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_CREATE  = 3'd1;
  localparam logic [2:0] REQ_SET_TGT = 3'd2;
  localparam logic [2:0] REQ_SET_VAL = 3'd3;
  localparam logic [2:0] REQ_SET_PAR = 3'd4;
  localparam logic [2:0] REQ_REMOVE  = 3'd5;
  localparam logic [2:0] REQ_QUERY   = 3'd6;
  localparam logic [2:0] REQ_NONE    = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_POS_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_THR = 1'd1;

  localparam logic [THR_W-1:0] THR_RESET = 31'd655;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [3:0]         slot;
    logic signed [31:0] operand_value;
    logic [31:0]        stiffness_in;
    logic [31:0]        damping_in;
    logic [31:0]        mass_in;
    logic [15:0]        time_step;
  } req_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic signed [31:0] velocity_out;
    logic signed [31:0] target_out;
    logic               settled;
    logic               slot_present;
    logic               error_flag;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] target;
    logic signed [31:0] velocity;
    logic [31:0]        stiffness;
    logic [31:0]        damping;
    logic [31:0]        inv_mass;
  } spring_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] v;
  } sat_t;

  // clamp a wide signed value to a signed word, flag when clamped
  function automatic sat_t sat_word(input logic signed [65:0] x);
    sat_t r;
    if ((&x[65:31]) || !(|x[65:31])) begin
      r.sat = 1'b0;
      r.v   = x[31:0];
    end else begin
      r.sat = 1'b1;
      r.v   = x[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // both |value - target| and |velocity| strictly under their bounds
  function automatic logic is_settled(input logic signed [31:0] val,
                                      input logic signed [31:0] tgt,
                                      input logic signed [31:0] vel,
                                      input logic [THR_W-1:0] pth,
                                      input logic [THR_W-1:0] vth);
    logic signed [32:0] d;
    logic [32:0] ad;
    logic [32:0] av;
    d  = {val[31], val} - {tgt[31], tgt};
    ad = d[32] ? 33'(-d) : 33'(d);
    av = vel[31] ? 33'(-{vel[31], vel}) : {1'b0, vel};
    return (ad < {2'b00, pth}) && (av < {2'b00, vth});
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dst_chan_if.sv
// Valid/ready channel carrying one payload word per handshake.
// Payload type is set per instance (dst_pkg::req_t or dst_pkg::rsp_t).
`default_nettype none
interface dst_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/dst_mul.sv
// Bit-serial signed x unsigned multiplier, one multiplier bit per cycle.
// Uses no package items beyond plain logic.
`default_nettype none
module dst_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [32:0] a,
  input  wire logic [31:0]        b,
  output logic                    done,
  output logic signed [64:0]      p
);
  logic signed [32:0] a_q;
  logic signed [33:0] hi;
  logic signed [33:0] hi_sum;
  logic [31:0]        lo;
  logic [4:0]         cnt;
  logic               busy;

  assign hi_sum = lo[0] ? hi + {a_q[32], a_q} : hi;
  assign p = {hi[32:0], lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= {hi_sum[33], hi_sum[33:1]};
      lo <= {hi_sum[0], lo[31:1]};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/dst_recip.sv
// Restoring divider: 2^(2*FRAC_BITS) / mass, one quotient bit per cycle.
// Imports dst_pkg, though it uses none of its items.
`default_nettype none
module dst_recip #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] mass,
  output logic             done,
  output logic             zero_mass,
  output logic [31:0]      inv
);
  import dst_pkg::*;

  localparam int DW  = 2 * FRAC_BITS + 1;
  localparam int CW  = $clog2(DW + 1);

  logic [31:0]   m;
  logic [31:0]   rem;
  logic [DW-1:0] dvd;
  logic [DW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [32:0]   trial;
  logic          ge;
  logic [63:0]   q64;

  assign trial = {rem, dvd[DW-1]};
  assign ge    = trial >= {1'b0, m};
  assign q64   = 64'(q);
  assign inv   = (|q64[63:32]) ? 32'hFFFF_FFFF : q64[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      zero_mass <= (mass == '0);
      m   <= (mass == '0) ? (32'd1 << FRAC_BITS) : mass;
      rem <= '0;
      dvd <= DW'(1) << (2 * FRAC_BITS);
      q   <= '0;
    end else if (busy) begin
      rem <= ge ? 32'(trial - {1'b0, m}) : trial[31:0];
      dvd <= dvd << 1;
      q   <= {q[DW-2:0], ge};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/damped_spring_table_step.sv
// Damped spring table: a slot request reads the row, loads it and writes it back (create,
// and set params on a present slot, also wait on the serial reciprocal-mass divider). A
// tick scans every slot; a settled spring snaps to its target and a moving one is stepped
// by four dependent bit-serial multiply stages (spring and damping terms run in
// parallel). One word is in flight at a time. Sync reset clears valid bits and the
// result valid flag, and sets thresholds to 655.
`default_nettype none
module damped_spring_table_step #(
  parameter int NUM_SPRINGS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  dst_chan_if.sink                         request,
  dst_chan_if.source                       result,
  input  wire logic                        cfg_we,
  input  wire logic [dst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dst_pkg::THR_W-1:0]   cfg_wdata
);
  import dst_pkg::*;

  localparam int AW = (NUM_SPRINGS > 1) ? $clog2(NUM_SPRINGS) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TNEXT = 4'd1;   // tick: find next valid slot
  localparam logic [3:0] ST_RD    = 4'd2;   // row read in flight
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_CHK   = 4'd4;   // settled check, launch force multiplies
  localparam logic [3:0] ST_M1    = 4'd5;   // k*d and c*v
  localparam logic [3:0] ST_F2    = 4'd6;   // force sum
  localparam logic [3:0] ST_M2    = 4'd7;   // sum * inv_mass
  localparam logic [3:0] ST_M3    = 4'd8;   // acc * dt
  localparam logic [3:0] ST_M4    = 4'd9;   // v * dt
  localparam logic [3:0] ST_TWB   = 4'd10;  // write back, settled check after step
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_SWB   = 4'd12;  // slot request write back
  localparam logic [3:0] ST_RESP  = 4'd13;

  logic [3:0] state;

  logic [THR_W-1:0]       pth;
  logic [THR_W-1:0]       vth;
  logic [NUM_SPRINGS-1:0] valid;

  // request word held for the whole operation
  logic [2:0]         r_req;
  logic signed [31:0] r_opv;
  logic [31:0]        r_k;
  logic [31:0]        r_c;
  logic [31:0]        r_m;
  logic [DT_W-1:0]    r_dt;

  logic [AW:0]   cnt;
  logic [AW-1:0] cur;
  logic          present;
  logic          live;
  logic          res_set;
  logic          all_set;
  logic          err;

  // working copy of the current spring
  logic signed [31:0] w_val;
  logic signed [31:0] w_tgt;
  logic signed [31:0] w_vel;
  logic [31:0]        w_k;
  logic [31:0]        w_c;
  logic [31:0]        w_im;
  logic signed [31:0] t1;
  logic signed [31:0] t2;

  // spring storage: one row per slot, registered read
  spring_t mem [NUM_SPRINGS];
  spring_t rd_row;
  spring_t mem_wdata;
  logic    mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur] <= mem_wdata;
    end
    rd_row <= mem[cur];
  end

  // slot decode
  logic [AW+3:0] slot_wide;
  logic          in_range;
  logic [AW-1:0] slot_addr;
  assign slot_wide = (AW + 4)'(request.data.slot);
  assign in_range  = slot_wide < (AW + 4)'(NUM_SPRINGS);
  assign slot_addr = slot_wide[AW-1:0];

  assign request.ready = (state == ST_IDLE);

  // multipliers and divider
  logic               ma_start, mb_start, ma_done, mb_done;
  logic signed [32:0] ma_a, mb_a;
  logic [31:0]        ma_b;
  logic signed [64:0] pa, pb;
  logic               dv_start, dv_done, dv_zero;
  logic [31:0]        dv_inv;

  dst_mul u_mul_a (.clk(clk), .rst(rst), .start(ma_start), .a(ma_a), .b(ma_b),
                   .done(ma_done), .p(pa));
  dst_mul u_mul_b (.clk(clk), .rst(rst), .start(mb_start), .a(mb_a), .b(w_c),
                   .done(mb_done), .p(pb));
  dst_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
    .clk(clk), .rst(rst), .start(dv_start), .mass(r_m),
    .done(dv_done), .zero_mass(dv_zero), .inv(dv_inv));

  // datapath around the multipliers
  logic               settled_now;
  logic signed [32:0] d33;
  sat_t               d_sat;
  logic signed [65:0] pa_ext, pb_ext;
  sat_t               pa_fr_sat, pb_fr_sat;
  logic signed [65:0] pa_dt;
  sat_t               sum_sat, vel_sat, val_sat;
  logic signed [32:0] t_sum;

  assign settled_now = is_settled(w_val, w_tgt, w_vel, pth, vth);
  assign d33       = {w_val[31], w_val} - {w_tgt[31], w_tgt};
  assign d_sat     = sat_word({{33{d33[32]}}, d33});
  assign pa_ext    = {pa[64], pa};
  assign pb_ext    = {pb[64], pb};
  assign pa_fr_sat = sat_word(pa_ext >>> FRAC_BITS);
  assign pb_fr_sat = sat_word(pb_ext >>> FRAC_BITS);
  assign pa_dt     = pa_ext >>> DT_BITS;
  assign t_sum     = {t1[31], t1} + {t2[31], t2};
  assign sum_sat   = sat_word({{33{t_sum[32]}}, t_sum});
  assign vel_sat   = sat_word({{34{w_vel[31]}}, w_vel} + pa_dt);
  assign val_sat   = sat_word({{34{w_val[31]}}, w_val} + pa_dt);

  // spring force is k * (-d), damping force c * (-v)
  assign mb_a     = 33'(-{w_vel[31], w_vel});
  assign mb_start = (state == ST_CHK) && !settled_now;

  always_comb begin
    ma_a     = 33'(-{d_sat.v[31], d_sat.v});
    ma_b     = w_k;
    ma_start = 1'b0;
    unique case (state)
      ST_CHK: begin
        ma_start = !settled_now;
      end
      ST_F2: begin
        ma_a     = {sum_sat.v[31], sum_sat.v};
        ma_b     = w_im;
        ma_start = 1'b1;
      end
      ST_M2: begin
        ma_a     = {pa_fr_sat.v[31], pa_fr_sat.v};
        ma_b     = 32'(r_dt);
        ma_start = ma_done;
      end
      ST_M3: begin
        ma_a     = {vel_sat.v[31], vel_sat.v};
        ma_b     = 32'(r_dt);
        ma_start = ma_done;
      end
      default: begin
      end
    endcase
  end

  logic slot_write;
  logic ld_val;   // new value, velocity cleared
  logic ld_tgt;   // new target
  logic ld_par;   // new stiffness, damping and reciprocal mass
  assign slot_write = (r_req == REQ_CREATE) ||
                      (present && (r_req == REQ_SET_TGT || r_req == REQ_SET_VAL ||
                                   r_req == REQ_SET_PAR));
  assign ld_val = (r_req == REQ_CREATE) || (present && r_req == REQ_SET_VAL);
  assign ld_tgt = (r_req == REQ_CREATE) || (present && r_req == REQ_SET_TGT);
  assign ld_par = (r_req == REQ_CREATE) || (present && r_req == REQ_SET_PAR);
  assign dv_start = (state == ST_LOAD) && (r_req != REQ_TICK) &&
                    ((r_req == REQ_CREATE) || (present && r_req == REQ_SET_PAR));

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '{value: w_val, target: w_tgt, velocity: w_vel,
                  stiffness: w_k, damping: w_c, inv_mass: w_im};
    if (state == ST_CHK && settled_now) begin
      // settled spring snaps to its target
      mem_we = 1'b1;
      mem_wdata.value    = w_tgt;
      mem_wdata.velocity = '0;
    end else if (state == ST_TWB) begin
      mem_we = 1'b1;
    end else if (state == ST_SWB) begin
      mem_we = slot_write;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pth <= THR_RESET;
      vth <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POS_THR: pth <= cfg_wdata;
        REG_VEL_THR: vth <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      valid        <= '0;
      result.valid <= 1'b0;
    end else begin
      // a word taken while the next one is loaded is handled in ST_RESP
      if (result.valid && result.ready && state != ST_RESP) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (request.valid) begin
            r_req <= request.data.req_type;
            r_opv <= request.data.operand_value;
            r_k   <= request.data.stiffness_in;
            r_c   <= request.data.damping_in;
            r_m   <= request.data.mass_in;
            r_dt  <= request.data.time_step;
            err     <= 1'b0;
            live    <= 1'b0;
            if (request.data.req_type == REQ_TICK) begin
              present <= 1'b0;
              cnt     <= '0;
              all_set <= 1'b1;
              state   <= ST_TNEXT;
            end else if (request.data.req_type == REQ_NONE) begin
              present <= 1'b0;
              res_set <= 1'b0;
              state   <= ST_RESP;
            end else if (in_range) begin
              cur     <= slot_addr;
              present <= valid[slot_addr];
              res_set <= 1'b1;
              state   <= ST_RD;
            end else begin
              present <= 1'b0;
              res_set <= 1'b1;
              state   <= ST_RESP;
            end
          end
        end
        ST_TNEXT: begin
          if (cnt == (AW + 1)'(NUM_SPRINGS)) begin
            res_set <= all_set;
            state   <= ST_RESP;
          end else if (valid[cnt[AW-1:0]]) begin
            cur   <= cnt[AW-1:0];
            state <= ST_RD;
          end else begin
            cnt <= cnt + (AW + 1)'(1);
          end
        end
        ST_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          w_val <= ld_val ? r_opv : rd_row.value;
          w_tgt <= ld_tgt ? r_opv : rd_row.target;
          w_vel <= ld_val ? 32'sd0 : rd_row.velocity;
          w_k   <= ld_par ? r_k : rd_row.stiffness;
          w_c   <= ld_par ? r_c : rd_row.damping;
          w_im  <= rd_row.inv_mass;
          if (r_req == REQ_TICK) begin
            state <= ST_CHK;
          end else if (ld_par) begin
            state <= ST_DIV;
          end else begin
            state <= ST_SWB;
          end
        end
        ST_CHK: begin
          if (settled_now) begin
            cnt   <= cnt + (AW + 1)'(1);
            state <= ST_TNEXT;
          end else begin
            err   <= err | d_sat.sat;
            state <= ST_M1;
          end
        end
        ST_M1: begin
          if (ma_done && mb_done) begin
            t1    <= pa_fr_sat.v;
            t2    <= pb_fr_sat.v;
            err   <= err | pa_fr_sat.sat | pb_fr_sat.sat;
            state <= ST_F2;
          end
        end
        ST_F2: begin
          err   <= err | sum_sat.sat;
          state <= ST_M2;
        end
        ST_M2: begin
          if (ma_done) begin
            err   <= err | pa_fr_sat.sat;
            state <= ST_M3;
          end
        end
        ST_M3: begin
          if (ma_done) begin
            w_vel <= vel_sat.v;
            err   <= err | vel_sat.sat;
            state <= ST_M4;
          end
        end
        ST_M4: begin
          if (ma_done) begin
            w_val <= val_sat.v;
            err   <= err | val_sat.sat;
            state <= ST_TWB;
          end
        end
        ST_TWB: begin
          if (!settled_now) all_set <= 1'b0;
          cnt   <= cnt + (AW + 1)'(1);
          state <= ST_TNEXT;
        end
        ST_DIV: begin
          if (dv_done) begin
            w_im  <= dv_inv;
            err   <= dv_zero;
            state <= ST_SWB;
          end
        end
        ST_SWB: begin
          if (r_req == REQ_CREATE) valid[cur] <= 1'b1;
          if (r_req == REQ_REMOVE) valid[cur] <= 1'b0;
          live  <= (r_req == REQ_CREATE) || (present && r_req != REQ_REMOVE);
          state <= ST_RESP;
        end
        ST_RESP: begin
          // output register free or being emptied this cycle
          if (!result.valid || result.ready) begin
            result.valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with the valid flag
  always_ff @(posedge clk) begin
    if (state == ST_RESP && (!result.valid || result.ready)) begin
      result.data.value_out    <= live ? w_val : '0;
      result.data.velocity_out <= live ? w_vel : '0;
      result.data.target_out   <= live ? w_tgt : '0;
      result.data.settled      <= live ? settled_now : res_set;
      result.data.slot_present <= present;
      result.data.error_flag   <= err;
    end
  end
endmodule
`default_nettype wire

>>> sim/damped_spring_table_step_tb.sv
// Self-checking bench for damped_spring_table_step: directed and random requests,
// checked word by word against an in-bench spring table predictor.
// Depends on dst_pkg, dst_chan_if and the block itself.
`default_nettype none
module damped_spring_table_step_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dst_pkg::*;

  localparam int SLOTS = 16;
  localparam int FRAC  = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_wdata = '0;

  dst_chan_if #(.T(req_t)) req_ch ();
  dst_chan_if #(.T(rsp_t)) rsp_ch ();

  damped_spring_table_step #(.NUM_SPRINGS(SLOTS), .FRAC_BITS(FRAC)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req_ch),
    .result    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Spring table predictor: own copy of thresholds and per-slot state
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]   pos_thr, vel_thr;
  bit                 live [SLOTS];
  logic signed [31:0] s_val [SLOTS], s_tgt [SLOTS], s_vel [SLOTS];
  logic [31:0]        s_k [SLOTS], s_c [SLOTS], s_im [SLOTS];

  rsp_t pending_rsp[$];   // predicted words not yet seen on the result side
  int   errors = 0;
  int   src_idle = 0;     // percent of cycles the sender holds back
  int   snk_idle = 0;     // percent of cycles the receiver stalls

  // saturate to a signed word; flag sticks once set
  function automatic logic signed [31:0] clamp32(input longint x, inout bit f);
    if (x > 64'sh7FFF_FFFF) begin
      f = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < 64'shFFFF_FFFF_8000_0000) begin
      f = 1'b1;
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic bit calm(input int i);
    longint d, v;
    d = longint'(s_val[i]) - longint'(s_tgt[i]);
    v = longint'(s_vel[i]);
    if (d < 0) d = -d;
    if (v < 0) v = -v;
    return d < longint'({33'b0, pos_thr}) && v < longint'({33'b0, vel_thr});
  endfunction

  // 2^32 / mass, zero mass counts as one (Q16.16) and raises the flag
  function automatic logic [31:0] inv_mass_of(input logic [31:0] m, inout bit f);
    longint unsigned mm, q;
    mm = (m == 0) ? 64'd65536 : {32'b0, m};
    if (m == 0) f = 1'b1;
    q = (64'd1 << 32) / mm;
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  // one semi-implicit Euler step; arithmetic shifts give floor rounding
  function automatic void step_spring(input int i, input logic [15:0] dt, inout bit f);
    logic signed [31:0] d, sum, acc, v, fsw, fdw;
    longint fs, fd, dv, dx, dtl;
    dtl = longint'({48'b0, dt});
    d   = clamp32(longint'(s_val[i]) - longint'(s_tgt[i]), f);
    fs  = (-(longint'({32'b0, s_k[i]}) * longint'(d))) >>> FRAC;
    fd  = (-(longint'({32'b0, s_c[i]}) * longint'(s_vel[i]))) >>> FRAC;
    fsw = clamp32(fs, f);
    fdw = clamp32(fd, f);
    sum = clamp32(longint'(fsw) + longint'(fdw), f);
    acc = clamp32((longint'(sum) * longint'({32'b0, s_im[i]})) >>> FRAC, f);
    dv  = (longint'(acc) * dtl) >>> DT_BITS;
    v   = clamp32(longint'(s_vel[i]) + dv, f);
    dx  = (longint'(v) * dtl) >>> DT_BITS;
    s_vel[i] = v;
    s_val[i] = clamp32(longint'(s_val[i]) + dx, f);
  endfunction

  function automatic rsp_t apply_request(input req_t r);
    rsp_t o;
    bit   f, all, was;
    int   s;
    o = '0;
    f = 1'b0;
    s = r.slot;
    if (r.req_type == REQ_NONE) return o;
    if (r.req_type == REQ_TICK) begin
      all = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
        if (!live[i]) continue;
        if (calm(i)) begin
          // settled spring snaps onto its target
          s_val[i] = s_tgt[i];
          s_vel[i] = 0;
          continue;
        end
        step_spring(i, r.time_step, f);
        if (!calm(i)) all = 1'b0;
      end
      o.settled = all;
      o.error_flag = f;
      return o;
    end
    was = live[s];
    case (r.req_type)
      REQ_CREATE: begin
        live[s]  = 1'b1;
        s_val[s] = r.operand_value;
        s_tgt[s] = r.operand_value;
        s_vel[s] = 0;
        s_k[s]   = r.stiffness_in;
        s_c[s]   = r.damping_in;
        s_im[s]  = inv_mass_of(r.mass_in, f);
      end
      REQ_SET_TGT: if (was) s_tgt[s] = r.operand_value;
      REQ_SET_VAL: if (was) begin
        s_val[s] = r.operand_value;
        s_vel[s] = 0;
      end
      REQ_SET_PAR: if (was) begin
        s_k[s]  = r.stiffness_in;
        s_c[s]  = r.damping_in;
        s_im[s] = inv_mass_of(r.mass_in, f);
      end
      REQ_REMOVE: live[s] = 1'b0;
      default: ;
    endcase
    if (live[s]) begin
      o.value_out    = s_val[s];
      o.velocity_out = s_vel[s];
      o.target_out   = s_tgt[s];
      o.settled      = calm(s);
    end else begin
      o.settled = 1'b1;
    end
    o.slot_present = was;
    o.error_flag   = f;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
  end

  // receiver stalls at random; zero percent means always ready
  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= snk_idle);

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("%0t ns mismatch on %s: expected %h, got %h", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_t got, want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_rsp.size() == 0) begin
        report("unexpected word", 32'h0, 32'h1);
      end else begin
        want = pending_rsp.pop_front();
        if (got.value_out !== want.value_out)
          report("value_out", want.value_out, got.value_out);
        if (got.velocity_out !== want.velocity_out)
          report("velocity_out", want.velocity_out, got.velocity_out);
        if (got.target_out !== want.target_out)
          report("target_out", want.target_out, got.target_out);
        if (got.settled !== want.settled)
          report("settled", 32'(want.settled), 32'(got.settled));
        if (got.slot_present !== want.slot_present)
          report("slot_present", 32'(want.slot_present), 32'(got.slot_present));
        if (got.error_flag !== want.error_flag)
          report("error_flag", 32'(want.error_flag), 32'(got.error_flag));
      end
    end
  end

  // entered and left at a falling edge; valid stays high between
  // back-to-back words so it gets a single assignment per step
  task automatic send_word(input req_t w);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_rsp = {pending_rsp, apply_request(w)};
    @(negedge clk);
  endtask

  task automatic send(input logic [2:0] op, input int s, input logic [31:0] v,
                      input logic [31:0] k, input logic [31:0] c, input logic [31:0] m,
                      input logic [15:0] dt);
    req_t w;
    w.req_type = op;
    w.slot = s[3:0];
    w.operand_value = v;
    w.stiffness_in = k;
    w.damping_in = c;
    w.mass_in = m;
    w.time_step = dt;
    send_word(w);
  endtask

  // every request yields a word, so an empty queue means the block is idle
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POS_THR) pos_thr = val;
    else vel_thr = val;
  endtask

  // mostly well-formed springs with moderate constants, some raw noise
  function automatic req_t rand_request();
    req_t w;
    int   p;
    p = $urandom_range(99);
    if (p < 15)      w.req_type = REQ_TICK;
    else if (p < 32) w.req_type = REQ_CREATE;
    else if (p < 44) w.req_type = REQ_SET_TGT;
    else if (p < 54) w.req_type = REQ_SET_VAL;
    else if (p < 63) w.req_type = REQ_SET_PAR;
    else if (p < 71) w.req_type = REQ_REMOVE;
    else if (p < 97) w.req_type = REQ_QUERY;
    else             w.req_type = REQ_NONE;
    w.slot = $urandom_range(15);
    w.operand_value = ($urandom_range(99) < 80)
        ? 32'($urandom_range(20 << 16)) - 32'(10 << 16) : 32'($urandom);
    if ($urandom_range(99) < 85) begin
      w.stiffness_in = $urandom_range(200 << 16, 1 << 16);
      w.damping_in   = $urandom_range(20 << 16);
      w.mass_in      = $urandom_range(8 << 16, 1 << 14);
    end else begin
      w.stiffness_in = $urandom;
      w.damping_in   = $urandom;
      w.mass_in      = $urandom;
    end
    if ($urandom_range(99) < 4) w.mass_in = 0;
    w.time_step = ($urandom_range(99) < 70) ? 16'($urandom_range(8192)) : 16'($urandom);
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // extremes, every request code, absent slots, zero mass, saturation
  task automatic test_directed();
    send(REQ_TICK, 0, 0, 0, 0, 0, 16'hFFFF);                 // tick on empty table
    send(REQ_QUERY, 0, 0, 0, 0, 0, 0);                        // absent slot
    send(REQ_SET_TGT, 3, 32'h1234_5678, 0, 0, 0, 0);          // ignored on absent slot
    send(REQ_SET_VAL, 3, 32'h8765_4321, 0, 0, 0, 0);
    send(REQ_SET_PAR, 3, 0, 1, 2, 0, 0);                      // no zero-mass flag here
    send(REQ_REMOVE, 3, 0, 0, 0, 0, 0);
    send(REQ_CREATE, 0, 32'h7FFF_FFFF, 32'h0001_0000, 0, 0, 0);   // zero mass
    send(REQ_CREATE, 15, 32'h8000_0000, '1, '1, 32'd1, 0);        // extreme params
    send(REQ_QUERY, 0, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 15, 0, 0, 0, 0, 0);
    send(REQ_SET_TGT, 0, 32'h8000_0000, 0, 0, 0, 0);          // huge displacement
    send(REQ_SET_TGT, 15, 32'h7FFF_FFFF, 0, 0, 0, 0);
    send(REQ_TICK, 0, 0, 0, 0, 0, 16'hFFFF);                  // saturates
    send(REQ_QUERY, 0, 0, 0, 0, 0, 0);
    send(REQ_TICK, 0, 0, 0, 0, 0, 16'h0000);                  // zero dt
    send(REQ_SET_VAL, 15, 0, 0, 0, 0, 0);
    send(REQ_SET_PAR, 0, 0, 32'h0004_0000, 32'h0000_8000, '1, 0);
    send(REQ_CREATE, 15, 32'h0002_0000, 32'h0010_0000, 32'h0001_0000, 32'h0001_0000, 0);
    send(REQ_NONE, 15, '1, '1, '1, '1, 16'hFFFF);             // unused code
    send(REQ_REMOVE, 15, 0, 0, 0, 0, 0);
    send(REQ_QUERY, 15, 0, 0, 0, 0, 0);
    send(REQ_REMOVE, 0, 0, 0, 0, 0, 0);
    send(REQ_TICK, 0, 0, 0, 0, 0, 16'h1000);
    drain();
  endtask

  // thresholds at zero (nothing settles), at max (everything settles), at reset value, random
  task automatic test_thresholds();
    logic [THR_W-1:0] sets [4];
    sets[0] = '0;
    sets[1] = '1;
    sets[2] = THR_RESET;
    sets[3] = '0;
    for (int n = 0; n < 4; n++) begin
      if (n == 3) begin
        sets[3] = THR_W'($urandom);
        cfg_write(REG_POS_THR, THR_W'($urandom_range(1 << 18)));
      end else begin
        cfg_write(REG_POS_THR, sets[n]);
      end
      cfg_write(REG_VEL_THR, sets[n]);
      for (int i = 0; i < 4; i++)
        send(REQ_CREATE, i, $urandom_range(1 << 16), 32'h0008_0000, 32'h0001_0000,
             32'h0001_0000, 0);
      send(REQ_SET_TGT, 1, 32'h0003_0000, 0, 0, 0, 0);
      repeat (3) send(REQ_TICK, 0, 0, 0, 0, 0, 16'h2000);
      for (int i = 0; i < 4; i++) send(REQ_QUERY, i, 0, 0, 0, 0, 0);
      drain();
    end
    cfg_write(REG_POS_THR, THR_RESET);
    cfg_write(REG_VEL_THR, THR_RESET);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) send_word(rand_request());
    drain();
  endtask

  initial begin
    pos_thr = THR_RESET;
    vel_thr = THR_RESET;
    foreach (live[i]) live[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // phase one: sender idles 32%, receiver 82%
    src_idle = 32;
    snk_idle = 82;
    test_directed();
    test_thresholds();
    test_random(560);
    // phase two: roles swapped
    src_idle = 82;
    snk_idle = 32;
    test_random(560);
    // phase three: full throughput both sides
    src_idle = 0;
    snk_idle = 0;
    test_random(600);

    // idle tail for any stray word
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_rsp.size() == 0)
      $display("damped_spring_table_step_tb: clean");
    else
      $display("damped_spring_table_step_tb: errors");
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #100ms;
    $display("damped_spring_table_step_tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
